@@ sv/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Included by bare name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, disabled in reset.
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ sv/sha256_pkg.sv @@
// Package for the SHA-256 stream hasher: round constants, initial hash values, rotate.
// No dependencies.
package sha256_pkg;
  typedef logic [31:0] word_t;

  localparam logic [60:0] MaxBytes = {61{1'b1}};

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85; 3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a; 3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction
endpackage

@@ sv/sha256_stream_hasher_unit.sv @@
// SHA-256 stream hasher top level: byte gathering, padding, round engine, digest out.
// Depends on sha256_pkg.
//
//  channel | dir | tdata (low bit up)              | tuser / tlast
//  s_axis  | in  | msg_byte[7:0]                   | tuser: byte_present; tlast: end_of_message
//  m_axis  | out | digest_word[31:0], word_number  | tuser: limit_exceeded; tlast: final_word
//
// A byte that fills no block is only stored. A byte that completes a 64-byte block
// passes through its accept, one load, 64 rounds of the single round unit and one
// chain update. An ending byte adds one or two padded blocks (a pad step, then load,
// rounds and chain update for each) and eight output words.
// Reset is synchronous; the block buffer needs no clearing. Output stalls hold the
// engine; input is not taken until the digest has been delivered.
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // msg_byte[7:0]
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_number[34:32], zero fill
  output logic        m_axis_tuser,   // limit_exceeded
  output logic        m_axis_tlast    // final_word
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SLoad = 3'd1;
  localparam logic [2:0] SRound = 3'd2;
  localparam logic [2:0] SAdd = 3'd3;
  localparam logic [2:0] SPad = 3'd4;
  localparam logic [2:0] SOut = 3'd5;

  logic [2:0] state;
  sha256_pkg::word_t chain [8];
  sha256_pkg::word_t wv [8];     // working variables a..h
  sha256_pkg::word_t sched [16]; // rolling message schedule window
  sha256_pkg::word_t blk [16];   // block buffer, big-endian bytes within each word
  logic [5:0] fill;
  logic [60:0] total;
  logic ovf;
  logic [5:0] rnd;
  logic ending;       // padding in progress
  logic len_done;     // a padded block has been built
  logic [2:0] onum;

  logic acc;
  logic present;
  assign s_axis_tready = (state == SIdle);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign present = s_axis_tuser && (total != sha256_pkg::MaxBytes);

  // Round unit.
  sha256_pkg::word_t t1, t2, s0w, s1w, wnew, wcur;
  always_comb begin
    wcur = sched[0];
    t1 = wv[7] + (sha256_pkg::rotr(wv[4], 6) ^ sha256_pkg::rotr(wv[4], 11)
         ^ sha256_pkg::rotr(wv[4], 25)) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
         + sha256_pkg::round_k(rnd) + wcur;
    t2 = (sha256_pkg::rotr(wv[0], 2) ^ sha256_pkg::rotr(wv[0], 13)
         ^ sha256_pkg::rotr(wv[0], 22))
         + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
    s0w = sha256_pkg::rotr(sched[1], 7) ^ sha256_pkg::rotr(sched[1], 18) ^ (sched[1] >> 3);
    s1w = sha256_pkg::rotr(sched[14], 17) ^ sha256_pkg::rotr(sched[14], 19)
          ^ (sched[14] >> 10);
    wnew = s1w + sched[9] + s0w + sched[0];
  end

  // Padding of the current block: bytes fill .. 63, and the length in the last two words.
  logic [63:0] bits;
  logic pad_two;  // 0x80 sits at 56 or later: length needs a second block
  logic len_here;
  sha256_pkg::word_t pad_blk [16];
  assign bits = {total, 3'b000};
  assign pad_two = (fill >= 6'd56);
  assign len_here = !pad_two || len_done;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (len_here && i == 14) pad_blk[i] = bits[63:32];
      else if (len_here && i == 15) pad_blk[i] = bits[31:0];
      else begin
        for (int j = 0; j < 4; j++) begin
          if (6'(4 * i + j) == fill && !len_done) pad_blk[i][31 - 8 * j -: 8] = 8'h80;
          else if (6'(4 * i + j) > fill || len_done) pad_blk[i][31 - 8 * j -: 8] = 8'h00;
          else pad_blk[i][31 - 8 * j -: 8] = blk[i][31 - 8 * j -: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      fill <= '0;
      total <= '0;
      ovf <= 1'b0;
      ending <= 1'b0;
      len_done <= 1'b0;
      onum <= '0;
      rnd <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::init_h(3'(i));
    end else begin
      case (state)
        SIdle: begin
          if (acc) begin
            if (s_axis_tuser && !present) ovf <= 1'b1;
            if (present) begin
              // The first byte of a word lands in its top bits.
              blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= s_axis_tdata;
              fill <= fill + 6'd1;
              total <= total + 61'd1;
            end
            ending <= s_axis_tlast;
            len_done <= 1'b0;
            if (present && fill == 6'd63) state <= SLoad;
            else if (s_axis_tlast) state <= SPad;
          end
        end
        SPad: begin
          for (int i = 0; i < 16; i++) blk[i] <= pad_blk[i];
          if (len_here) ending <= 1'b0;
          len_done <= 1'b1;  // a second block carries zeros and length only
          fill <= '0;
          state <= SLoad;
        end
        SLoad: begin
          for (int i = 0; i < 16; i++) sched[i] <= blk[i];
          for (int i = 0; i < 8; i++) wv[i] <= chain[i];
          rnd <= '0;
          state <= SRound;
        end
        SRound: begin
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) sched[i] <= sched[i+1];
          sched[15] <= wnew;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= SAdd;
        end
        SAdd: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wv[i];
          fill <= '0;
          if (ending) state <= SPad;
          else if (len_done) begin
            onum <= '0;
            state <= SOut;
          end else state <= SIdle;
        end
        SOut: begin
          if (m_axis_tready) begin
            onum <= onum + 3'd1;
            if (onum == 3'd7) begin
              for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::init_h(3'(i));
              total <= '0;
              ovf <= 1'b0;
              len_done <= 1'b0;
              state <= SIdle;
            end
          end
        end
        default: state <= SIdle;
      endcase
    end
  end

  assign m_axis_tvalid = (state == SOut);
  assign m_axis_tdata = {5'b0, onum, chain[onum]};
  assign m_axis_tuser = ovf;
  assign m_axis_tlast = (onum == 3'd7);
endmodule

@@ sv/sha256_checker.sv @@
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  // Input is never taken while a digest word is offered.
  `CHK_IMPL(no_overlap, clk, rst, m_axis_tvalid, !s_axis_tready)
  // The last word is always word seven.
  `CHK_IMPL(last_is_seven, clk, rst, m_axis_tvalid && m_axis_tlast,
    m_axis_tdata[34:32] == 3'd7)
  // A taken word that is not last is followed by the next index.
  `CHK_NEXT(index_steps, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
    m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
  // Stalled output holds its word.
  `CHK_NEXT(hold_stall, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind sha256_stream_hasher_unit sha256_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
